// ----- design/wfv_pkg.sv -----
package wfv_pkg;

   // Sizes of the waypoint store and fixed-point formats
   localparam int MAX_POINTS = 64;
   localparam int PT_AW      = $clog2(MAX_POINTS);
   localparam int CNT_W      = PT_AW + 1;
   localparam int FRAC_BITS  = 16;
   localparam int GAIN_FRAC  = 8;
   localparam int QUO_W      = FRAC_BITS + 1;
   localparam int WP_W       = 32 + 32 + 32 + 31;
   localparam int ITER_W     = 6;
   localparam int SQRT_STEPS = 32;

   // Item operations
   localparam logic OPER_LOAD = 1'b0;
   localparam logic OPER_POSE = 1'b1;

   // Register indexes
   localparam logic [2:0] REG_START_MODE   = 3'd0;
   localparam logic [2:0] REG_POINT_COUNT  = 3'd1;
   localparam logic [2:0] REG_RUN_BAND     = 3'd2;
   localparam logic [2:0] REG_LOCK_BAND    = 3'd3;
   localparam logic [2:0] REG_HEADING_BAND = 3'd4;
   localparam logic [2:0] REG_HEADING_GAIN = 3'd5;
   localparam logic [2:0] REG_LOCK_GAIN    = 3'd6;
   localparam logic [2:0] REG_SPEED_SCALE  = 3'd7;

   // Datapath commands
   localparam logic [4:0] OP_NONE      = 5'd0;
   localparam logic [4:0] OP_LATCH     = 5'd1;
   localparam logic [4:0] OP_LOAD      = 5'd2;
   localparam logic [4:0] OP_DIFF      = 5'd3;
   localparam logic [4:0] OP_ABS       = 5'd4;
   localparam logic [4:0] OP_NOARR     = 5'd5;
   localparam logic [4:0] OP_KEEPARR   = 5'd6;
   localparam logic [4:0] OP_ADVANCE   = 5'd7;
   localparam logic [4:0] OP_FINISH    = 5'd8;
   localparam logic [4:0] OP_TURN      = 5'd9;
   localparam logic [4:0] OP_LOCKX     = 5'd10;
   localparam logic [4:0] OP_LOCKY     = 5'd11;
   localparam logic [4:0] OP_HALF      = 5'd12;
   localparam logic [4:0] OP_SQX       = 5'd13;
   localparam logic [4:0] OP_SQY       = 5'd14;
   localparam logic [4:0] OP_SQ_STEP   = 5'd15;
   localparam logic [4:0] OP_ZERO_VEL  = 5'd16;
   localparam logic [4:0] OP_DIVX_INIT = 5'd17;
   localparam logic [4:0] OP_DIV_STEP  = 5'd18;
   localparam logic [4:0] OP_MUL1X     = 5'd19;
   localparam logic [4:0] OP_MUL2X     = 5'd20;
   localparam logic [4:0] OP_DIVY_INIT = 5'd21;
   localparam logic [4:0] OP_MUL1Y     = 5'd22;
   localparam logic [4:0] OP_MUL2Y     = 5'd23;
   localparam logic [4:0] OP_PUSH      = 5'd24;

   typedef struct packed {
      logic               operation;
      logic [PT_AW-1:0]   point_slot;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_heading;
      logic [30:0]        waypoint_speed;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_turn;
      logic               arrived;
   } rsp_word_type;

   typedef struct packed {
      logic        start_mode;
      logic [6:0]  point_count;
      logic [30:0] run_band;
      logic [30:0] lock_band;
      logic [30:0] heading_band;
      logic [15:0] heading_gain;
      logic [15:0] lock_gain;
      logic [15:0] run_speed_scale;
   } csr_type;

   typedef struct packed {
      logic wr;
      logic val;
   } mode_evt_type;

   typedef struct packed {
      logic [4:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic finished;
      logic in_band;
      logic last;
      logic lock;
      logic sq_last;
      logic div_last;
      logic chord_zero;
      logic out_free;
   } dp_sts_type;

   // Saturate a magnitude with a sign to a signed 32-bit word
   function automatic logic [31:0] sat_out(input logic neg, input logic [64:0] mag);
      logic [64:0] lim;
      begin
         if (!neg) begin
            lim = (mag > 65'h7FFF_FFFF) ? 65'h7FFF_FFFF : mag;
            sat_out = lim[31:0];
         end else begin
            lim = (mag > 65'h8000_0000) ? 65'h8000_0000 : mag;
            sat_out = 32'd0 - lim[31:0];
         end
      end
   endfunction

endpackage

// ----- design/wfv_ram.sv -----
module wfv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/wfv_ctrl.sv -----
module wfv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_op,
   output logic                req_stall,
   input  wfv_pkg::dp_sts_type sts,
   output wfv_pkg::dp_cmd_type cmd
);
   import wfv_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DIFF   = 5'd1;
   localparam logic [4:0] S_ABS    = 5'd2;
   localparam logic [4:0] S_EVAL   = 5'd3;
   localparam logic [4:0] S_REREAD = 5'd4;
   localparam logic [4:0] S_TURN   = 5'd5;
   localparam logic [4:0] S_LX     = 5'd6;
   localparam logic [4:0] S_LY     = 5'd7;
   localparam logic [4:0] S_HALF   = 5'd8;
   localparam logic [4:0] S_SQX    = 5'd9;
   localparam logic [4:0] S_SQY    = 5'd10;
   localparam logic [4:0] S_SQ     = 5'd11;
   localparam logic [4:0] S_CHORD  = 5'd12;
   localparam logic [4:0] S_DIVX   = 5'd13;
   localparam logic [4:0] S_M1X    = 5'd14;
   localparam logic [4:0] S_M2X    = 5'd15;
   localparam logic [4:0] S_DIVYI  = 5'd16;
   localparam logic [4:0] S_DIVY   = 5'd17;
   localparam logic [4:0] S_M1Y    = 5'd18;
   localparam logic [4:0] S_M2Y    = 5'd19;
   localparam logic [4:0] S_PUSH   = 5'd20;

   logic [4:0] state_ff, state_in;
   logic       pass2_ff, pass2_in;

   assign req_stall = (state_ff != S_IDLE);

   // Sequence one item through the datapath
   always_comb begin
      state_in = state_ff;
      pass2_in = pass2_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OPER_POSE) begin
                  cmd.op   = OP_LATCH;
                  state_in = S_DIFF;
               end else begin
                  cmd.op = OP_LOAD;
               end
            end
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = S_ABS;
         end
         S_ABS: begin
            cmd.op   = OP_ABS;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            priority if (pass2_ff) begin
               cmd.op   = OP_NOARR;
               state_in = S_TURN;
            end else if (sts.finished) begin
               cmd.op   = OP_KEEPARR;
               state_in = S_TURN;
            end else if (sts.in_band && sts.last) begin
               cmd.op   = OP_FINISH;
               state_in = S_PUSH;
            end else if (sts.in_band) begin
               cmd.op   = OP_ADVANCE;
               pass2_in = 1'b1;
               state_in = S_REREAD;
            end else begin
               cmd.op   = OP_NOARR;
               state_in = S_TURN;
            end
         end
         S_REREAD: state_in = S_DIFF;
         S_TURN: begin
            cmd.op   = OP_TURN;
            state_in = sts.lock ? S_LX : S_HALF;
         end
         S_LX: begin
            cmd.op   = OP_LOCKX;
            state_in = S_LY;
         end
         S_LY: begin
            cmd.op   = OP_LOCKY;
            state_in = S_PUSH;
         end
         S_HALF: begin
            cmd.op   = OP_HALF;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.op   = OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = OP_SQY;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op = OP_SQ_STEP;
            if (sts.sq_last) begin
               state_in = S_CHORD;
            end
         end
         S_CHORD: begin
            if (sts.chord_zero) begin
               cmd.op   = OP_ZERO_VEL;
               state_in = S_PUSH;
            end else begin
               cmd.op   = OP_DIVX_INIT;
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            cmd.op = OP_DIV_STEP;
            if (sts.div_last) begin
               state_in = S_M1X;
            end
         end
         S_M1X: begin
            cmd.op   = OP_MUL1X;
            state_in = S_M2X;
         end
         S_M2X: begin
            cmd.op   = OP_MUL2X;
            state_in = S_DIVYI;
         end
         S_DIVYI: begin
            cmd.op   = OP_DIVY_INIT;
            state_in = S_DIVY;
         end
         S_DIVY: begin
            cmd.op = OP_DIV_STEP;
            if (sts.div_last) begin
               state_in = S_M1Y;
            end
         end
         S_M1Y: begin
            cmd.op   = OP_MUL1Y;
            state_in = S_M2Y;
         end
         S_M2Y: begin
            cmd.op   = OP_MUL2Y;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (sts.out_free) begin
               cmd.op   = OP_PUSH;
               pass2_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
      end
   end

   // A second pass never advances the target again
   a_pass2_no_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && pass2_ff) |-> (cmd.op == OP_NOARR))
      else $error("second pass issued a band decision");

   // Pushing leaves the controller idle and clears the pass flag
   a_push_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH) |=> (state_ff == S_IDLE && !pass2_ff))
      else $error("push did not return to idle");

endmodule

// ----- design/wfv_dp.sv -----
module wfv_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  wfv_pkg::dp_cmd_type   cmd,
   output wfv_pkg::dp_sts_type   sts,
   input  wfv_pkg::csr_type      csr,
   input  wfv_pkg::mode_evt_type mode_evt,
   input  wfv_pkg::req_word_type req_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output wfv_pkg::rsp_word_type rsp_data
);
   import wfv_pkg::*;

   logic signed [31:0] px_ff, px_in, py_ff, py_in, ph_ff, ph_in;
   logic signed [32:0] ex_ff, ex_in, ey_ff, ey_in, d_ff, d_in;
   logic [30:0]        spd_ff, spd_in;
   logic [32:0]        ax_ff, ax_in, ay_ff, ay_in, ad_ff, ad_in;
   logic               sx_ff, sx_in, sy_ff, sy_in, sd_ff, sd_in;
   logic [63:0]        sqx_ff, sqx_in, val_ff, val_in;
   logic [33:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [31:0]        drem_ff, drem_in;
   logic [QUO_W-1:0]   q_ff, q_in;
   logic [31:0]        t_ff, t_in;
   logic [31:0]        vx_ff, vx_in, vy_ff, vy_in, turn_ff, turn_in;
   logic               arr_ff, arr_in;
   logic [CNT_W-1:0]   target_ff, target_in;
   logic               lock_ff, lock_in;
   rsp_word_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]   count, rd_idx;
   logic [WP_W-1:0]    wr_word, rd_word;
   logic signed [31:0] wp_x, wp_y, wp_h;
   logic [30:0]        wp_v;
   logic [33:0]        man_dist;
   logic [30:0]        band;
   logic [32:0]        mul_a;
   logic [31:0]        mul_b;
   logic [64:0]        prod, prod_g;
   logic [35:0]        sq_rt, sq_trial, sq_diff;
   logic               sq_ge;
   logic [32:0]        dv_rt, dv_diff;
   logic               dv_ge;

   // Path length and the slot read for the current target
   assign count  = (csr.point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : csr.point_count[CNT_W-1:0];
   assign rd_idx = (target_ff >= count) ?
                   ((target_ff == '0) ? '0 : target_ff - CNT_W'(1)) : target_ff;

   assign wr_word = {req_data.pos_x, req_data.pos_y, req_data.pos_heading,
                     req_data.waypoint_speed};

   wfv_ram #(.WIDTH(WP_W), .DEPTH(MAX_POINTS)) u_store (
      .clock (clock),
      .we    (cmd.op == OP_LOAD),
      .waddr (req_data.point_slot),
      .wdata (wr_word),
      .raddr (rd_idx[PT_AW-1:0]),
      .rdata (rd_word)
   );

   assign wp_x = rd_word[126:95];
   assign wp_y = rd_word[94:63];
   assign wp_h = rd_word[62:31];
   assign wp_v = rd_word[30:0];

   // Manhattan band test for the current mode
   assign band     = lock_ff ? csr.lock_band : csr.run_band;
   assign man_dist = {1'b0, ax_ff} + {1'b0, ay_ff};

   // Shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_TURN:  begin mul_a = ad_ff; mul_b = {16'd0, csr.heading_gain}; end
         OP_LOCKX: begin mul_a = ax_ff; mul_b = {16'd0, csr.lock_gain}; end
         OP_LOCKY: begin mul_a = ay_ff; mul_b = {16'd0, csr.lock_gain}; end
         OP_SQX:   begin mul_a = ax_ff; mul_b = ax_ff[31:0]; end
         OP_SQY:   begin mul_a = ay_ff; mul_b = ay_ff[31:0]; end
         OP_MUL1X, OP_MUL1Y: begin
            mul_a = {2'b00, spd_ff};
            mul_b = {{(32-QUO_W){1'b0}}, q_ff};
         end
         OP_MUL2X, OP_MUL2Y: begin
            mul_a = {1'b0, t_ff};
            mul_b = {16'd0, csr.run_speed_scale};
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod   = {32'd0, mul_a} * {33'd0, mul_b};
   assign prod_g = prod >> GAIN_FRAC;

   // One root bit per step
   assign sq_rt    = {rem_ff, val_ff[63:62]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = (sq_rt >= sq_trial);
   assign sq_diff  = sq_rt - sq_trial;

   // One quotient bit per step, divisor is the chord
   assign dv_rt   = {drem_ff, q_ff[QUO_W-1]};
   assign dv_ge   = (dv_rt >= {1'b0, root_ff});
   assign dv_diff = dv_rt - {1'b0, root_ff};

   always_comb begin
      px_in = px_ff; py_in = py_ff; ph_in = ph_ff;
      ex_in = ex_ff; ey_in = ey_ff; d_in = d_ff; spd_in = spd_ff;
      ax_in = ax_ff; ay_in = ay_ff; ad_in = ad_ff;
      sx_in = sx_ff; sy_in = sy_ff; sd_in = sd_ff;
      sqx_in = sqx_ff; val_in = val_ff; rem_in = rem_ff; root_in = root_ff;
      iter_in = iter_ff; drem_in = drem_ff; q_in = q_ff; t_in = t_ff;
      vx_in = vx_ff; vy_in = vy_ff; turn_in = turn_ff; arr_in = arr_ff;
      target_in = target_ff; lock_in = lock_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cmd.op)
         OP_LATCH: begin
            px_in = req_data.pos_x;
            py_in = req_data.pos_y;
            ph_in = req_data.pos_heading;
         end
         OP_DIFF: begin
            ex_in  = 33'(wp_x) - 33'(px_ff);
            ey_in  = 33'(wp_y) - 33'(py_ff);
            d_in   = 33'(wp_h) - 33'(ph_ff);
            spd_in = wp_v;
         end
         OP_ABS: begin
            ax_in = ex_ff[32] ? 33'(-ex_ff) : 33'(ex_ff);
            ay_in = ey_ff[32] ? 33'(-ey_ff) : 33'(ey_ff);
            ad_in = d_ff[32] ? 33'(-d_ff) : 33'(d_ff);
            sx_in = ex_ff[32];
            sy_in = ey_ff[32];
            sd_in = d_ff[32];
         end
         OP_NOARR:   arr_in = 1'b0;
         OP_KEEPARR: arr_in = (man_dist < {3'd0, band});
         OP_ADVANCE: begin
            arr_in    = 1'b0;
            target_in = target_ff + CNT_W'(1);
         end
         OP_FINISH: begin
            arr_in    = 1'b1;
            target_in = target_ff + CNT_W'(1);
            lock_in   = 1'b1;
            vx_in     = '0;
            vy_in     = '0;
         end
         OP_TURN: begin
            turn_in = (ad_ff <= {2'b00, csr.heading_band}) ? 32'd0 : sat_out(!sd_ff, prod_g);
         end
         OP_LOCKX: vx_in = sat_out(sx_ff, prod_g);
         OP_LOCKY: vy_in = sat_out(sy_ff, prod_g);
         OP_HALF: begin
            if (ax_ff[32] || ax_ff[31] || ay_ff[32] || ay_ff[31]) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end
         end
         OP_SQX: sqx_in = prod[63:0];
         OP_SQY: begin
            val_in  = sqx_ff + prod[63:0];
            rem_in  = '0;
            root_in = '0;
            iter_in = '0;
         end
         OP_SQ_STEP: begin
            rem_in  = sq_ge ? sq_diff[33:0] : sq_rt[33:0];
            root_in = {root_ff[30:0], sq_ge};
            val_in  = val_ff << 2;
            iter_in = iter_ff + ITER_W'(1);
         end
         OP_ZERO_VEL: begin
            vx_in = '0;
            vy_in = '0;
         end
         OP_DIVX_INIT: begin
            drem_in = {1'b0, ax_ff[31:1]};
            q_in    = {ax_ff[0], {FRAC_BITS{1'b0}}};
            iter_in = '0;
         end
         OP_DIVY_INIT: begin
            drem_in = {1'b0, ay_ff[31:1]};
            q_in    = {ay_ff[0], {FRAC_BITS{1'b0}}};
            iter_in = '0;
         end
         OP_DIV_STEP: begin
            drem_in = dv_ge ? dv_diff[31:0] : dv_rt[31:0];
            q_in    = {q_ff[QUO_W-2:0], dv_ge};
            iter_in = iter_ff + ITER_W'(1);
         end
         OP_MUL1X, OP_MUL1Y: t_in = prod[FRAC_BITS +: 32];
         OP_MUL2X: vx_in = sat_out(sx_ff, prod_g);
         OP_MUL2Y: vy_in = sat_out(sy_ff, prod_g);
         OP_PUSH: begin
            rsp_in.vel_x    = vx_ff;
            rsp_in.vel_y    = vy_ff;
            rsp_in.vel_turn = turn_ff;
            rsp_in.arrived  = arr_ff;
            rsp_valid_in    = 1'b1;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
      // Restart the path on a mode write
      if (mode_evt.wr) begin
         lock_in   = mode_evt.val;
         target_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in; py_ff <= py_in; ph_ff <= ph_in;
      ex_ff <= ex_in; ey_ff <= ey_in; d_ff <= d_in; spd_ff <= spd_in;
      ax_ff <= ax_in; ay_ff <= ay_in; ad_ff <= ad_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sd_ff <= sd_in;
      sqx_ff <= sqx_in; val_ff <= val_in; rem_ff <= rem_in; root_ff <= root_in;
      iter_ff <= iter_in; drem_ff <= drem_in; q_ff <= q_in; t_ff <= t_in;
      arr_ff <= arr_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         lock_ff      <= 1'b0;
         vx_ff        <= '0;
         vy_ff        <= '0;
         turn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         lock_ff      <= lock_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         turn_ff      <= turn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.finished   = (target_ff >= count);
   assign sts.in_band    = (man_dist < {3'd0, band});
   assign sts.last       = ((target_ff + CNT_W'(1)) >= count);
   assign sts.lock       = lock_ff;
   assign sts.sq_last    = (iter_ff == ITER_W'(SQRT_STEPS - 1));
   assign sts.div_last   = (iter_ff == ITER_W'(QUO_W - 1));
   assign sts.chord_zero = (root_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Target never runs past the end of the store
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      target_ff <= CNT_W'(MAX_POINTS))
      else $error("target index out of range");

   // A new word is loaded only when the output stage is free
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output word overwritten");

   // Advance only while the path is unfinished
   a_advance_open: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ADVANCE || cmd.op == OP_FINISH) |-> !sts.finished)
      else $error("advance past path end");

   // Division starts only with a nonzero chord
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIVX_INIT) |-> (root_ff != '0))
      else $error("division by zero chord");

endmodule

// ----- design/waypoint_follower_velocity.sv -----
// Waypoint follower: load words (operation 0) store a waypoint in its slot and
// give no result; pose words (operation 1) run one planning step and give one
// result word. A load word never stalls the input. A pose word holds the input
// stalled until its result is pushed; the result is valid in the cycle after
// the push. Lock mode skips the square root and divisions, a target advance
// runs a second pass, and passing the last waypoint goes straight to the push.
// Run mode uses a bit-serial square root of 32 steps and two restoring
// divisions of 17 steps sharing one divider. A finished word waits in the
// output register while the next input word is taken. Configure over the
// register port only while idle; writing start_mode restarts the path.
module waypoint_follower_velocity (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wfv_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wfv_pkg::rsp_word_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import wfv_pkg::*;

   csr_type      csr_ff, csr_in;
   mode_evt_type mode_evt;
   dp_cmd_type   cmd;
   dp_sts_type   sts;
   logic         wr_en;
   logic [2:0]   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   // Register writes
   always_comb begin
      csr_in = csr_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_START_MODE:   csr_in.start_mode      = pwdata[0];
            REG_POINT_COUNT:  csr_in.point_count     = pwdata[6:0];
            REG_RUN_BAND:     csr_in.run_band        = pwdata[30:0];
            REG_LOCK_BAND:    csr_in.lock_band       = pwdata[30:0];
            REG_HEADING_BAND: csr_in.heading_band    = pwdata[30:0];
            REG_HEADING_GAIN: csr_in.heading_gain    = pwdata[15:0];
            REG_LOCK_GAIN:    csr_in.lock_gain       = pwdata[15:0];
            REG_SPEED_SCALE:  csr_in.run_speed_scale = pwdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_mode      <= 1'b0;
         csr_ff.point_count     <= 7'd0;
         csr_ff.run_band        <= 31'd655360;
         csr_ff.lock_band       <= 31'd65536;
         csr_ff.heading_band    <= 31'd65536;
         csr_ff.heading_gain    <= 16'd256;
         csr_ff.lock_gain       <= 16'd256;
         csr_ff.run_speed_scale <= 16'd256;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (reg_idx)
         REG_START_MODE:   prdata = {31'd0, csr_ff.start_mode};
         REG_POINT_COUNT:  prdata = {25'd0, csr_ff.point_count};
         REG_RUN_BAND:     prdata = {1'b0, csr_ff.run_band};
         REG_LOCK_BAND:    prdata = {1'b0, csr_ff.lock_band};
         REG_HEADING_BAND: prdata = {1'b0, csr_ff.heading_band};
         REG_HEADING_GAIN: prdata = {16'd0, csr_ff.heading_gain};
         REG_LOCK_GAIN:    prdata = {16'd0, csr_ff.lock_gain};
         REG_SPEED_SCALE:  prdata = {16'd0, csr_ff.run_speed_scale};
      endcase
   end

   assign mode_evt.wr  = wr_en && (reg_idx == REG_START_MODE);
   assign mode_evt.val = pwdata[0];

   wfv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wfv_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr       (csr_ff),
      .mode_evt  (mode_evt),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/waypoint_follower_velocity_test.sv -----
`timescale 1ns / 1ps

module waypoint_follower_velocity_test;
   import wfv_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [4:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   waypoint_follower_velocity u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Planner copy: configuration, waypoint store and path state
   bit              cf_start_mode;
   logic [6:0]      cf_point_count;
   longint          cf_run_band, cf_lock_band, cf_heading_band;
   longint          cf_heading_gain, cf_lock_gain, cf_speed_scale;
   longint          wp_x [MAX_POINTS];
   longint          wp_y [MAX_POINTS];
   longint          wp_h [MAX_POINTS];
   longint          wp_v [MAX_POINTS];
   int              target_idx;
   bit              lock_mode;
   logic [31:0]     last_vx, last_vy, last_turn;

   rsp_word_type    velocity_queue[$];
   req_word_type    pending_words[$];
   int              errors = 0;
   bit              hold_req = 1'b0;
   bit              quiet = 1'b0;
   int              req_gap = 0;
   int              rsp_gap = 0;

   // Stimulus-side copy of the path, used to aim poses near waypoints
   longint          gen_x [MAX_POINTS];
   longint          gen_y [MAX_POINTS];
   longint          gen_h [MAX_POINTS];
   int              gen_aim;

   initial forever #5 clock = ~clock;

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] clamp_word(bit neg, longint unsigned m);
      if (!neg) return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'd0 - m[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Velocity and turn toward waypoint i
   function automatic void steer_toward(int i, longint px, longint py, longint ph);
      longint ex, ey, d;
      longint unsigned ax, ay, chord, ux, uy, mx, my;
      ex = wp_x[i] - px;
      ey = wp_y[i] - py;
      ax = mag(ex);
      ay = mag(ey);
      if (lock_mode) begin
         last_vx = clamp_word(ex < 0, (ax * cf_lock_gain) >> GAIN_FRAC);
         last_vy = clamp_word(ey < 0, (ay * cf_lock_gain) >> GAIN_FRAC);
      end else begin
         if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
            ax = ax >> 1;
            ay = ay >> 1;
         end
         chord = int_sqrt(ax * ax + ay * ay);
         if (chord == 0) begin
            last_vx = '0;
            last_vy = '0;
         end else begin
            ux = (ax << FRAC_BITS) / chord;
            uy = (ay << FRAC_BITS) / chord;
            mx = (((wp_v[i] * ux) >> FRAC_BITS) * cf_speed_scale) >> GAIN_FRAC;
            my = (((wp_v[i] * uy) >> FRAC_BITS) * cf_speed_scale) >> GAIN_FRAC;
            last_vx = clamp_word(ex < 0, mx);
            last_vy = clamp_word(ey < 0, my);
         end
      end
      d = wp_h[i] - ph;
      if (d >= -cf_heading_band && d <= cf_heading_band) last_turn = '0;
      else last_turn = clamp_word(d > 0, (mag(d) * cf_heading_gain) >> GAIN_FRAC);
   endfunction

   function automatic bit near_point(int i, longint px, longint py);
      longint unsigned man_dist;
      man_dist = mag(px - wp_x[i]) + mag(py - wp_y[i]);
      return man_dist < longint'(lock_mode ? cf_lock_band : cf_run_band);
   endfunction

   // One planning step for an accepted pose word
   function automatic rsp_word_type plan_step(req_word_type w);
      rsp_word_type r;
      int           cnt, idx;
      longint       px, py, ph;
      px = w.pos_x;
      py = w.pos_y;
      ph = w.pos_heading;
      cnt = (cf_point_count < MAX_POINTS) ? cf_point_count : MAX_POINTS;
      r.arrived = 1'b0;
      if (target_idx >= cnt) begin
         idx = (target_idx > 0) ? target_idx - 1 : 0;
         if (idx >= MAX_POINTS) idx = MAX_POINTS - 1;
         steer_toward(idx, px, py, ph);
         r.arrived = near_point(idx, px, py);
      end else if (near_point(target_idx, px, py)) begin
         target_idx++;
         if (target_idx >= cnt) begin
            last_vx = '0;
            last_vy = '0;
            lock_mode = 1'b1;
            r.arrived = 1'b1;
         end else begin
            steer_toward(target_idx, px, py, ph);
         end
      end else begin
         steer_toward(target_idx, px, py, ph);
      end
      r.vel_x = last_vx;
      r.vel_y = last_vy;
      r.vel_turn = last_turn;
      return r;
   endfunction

   // Drive the request channel from the pending queue; predict on accept
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.operation == OPER_LOAD) begin
               wp_x[req_data.point_slot] = req_data.pos_x;
               wp_y[req_data.point_slot] = req_data.pos_y;
               wp_h[req_data.point_slot] = req_data.pos_heading;
               wp_v[req_data.point_slot] = req_data.waypoint_speed;
            end else begin
               velocity_queue.push_back(plan_step(req_data));
            end
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (!hold_req && pending_words.size() > 0) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
               req_gap = gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each result word against the oldest expectation; stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (velocity_queue.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               rsp_word_type e;
               e = velocity_queue.pop_front();
               if (rsp_data.vel_x !== e.vel_x) begin
                  $error("vel_x expected %0d got %0d", e.vel_x, rsp_data.vel_x);
                  errors++;
               end
               if (rsp_data.vel_y !== e.vel_y) begin
                  $error("vel_y expected %0d got %0d", e.vel_y, rsp_data.vel_y);
                  errors++;
               end
               if (rsp_data.vel_turn !== e.vel_turn) begin
                  $error("vel_turn expected %0d got %0d", e.vel_turn, rsp_data.vel_turn);
                  errors++;
               end
               if (rsp_data.arrived !== e.arrived) begin
                  $error("arrived expected %0b got %0b", e.arrived, rsp_data.arrived);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_gap = gap_len();
            rsp_stall <= (rsp_gap > 0);
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_load(int slot, longint x, longint y, longint h, longint v);
      req_word_type w;
      w = '0;
      w.operation = OPER_LOAD;
      w.point_slot = PT_AW'(slot);
      w.pos_x = 32'(x);
      w.pos_y = 32'(y);
      w.pos_heading = 32'(h);
      w.waypoint_speed = 31'(v);
      gen_x[slot] = w.pos_x;
      gen_y[slot] = w.pos_y;
      gen_h[slot] = w.pos_heading;
      pending_words.push_back(w);
   endtask

   task automatic push_pose(longint x, longint y, longint h);
      req_word_type w;
      w.operation = OPER_POSE;
      w.point_slot = PT_AW'($urandom);
      w.pos_x = 32'(x);
      w.pos_y = 32'(y);
      w.pos_heading = 32'(h);
      w.waypoint_speed = 31'($urandom);
      pending_words.push_back(w);
   endtask

   // Wait until every word is taken and every result has come, then settle
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || req_gap > 0
             || velocity_queue.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_START_MODE: begin
            cf_start_mode = val[0];
            lock_mode = val[0];
            target_idx = 0;
         end
         REG_POINT_COUNT:  cf_point_count = val[6:0];
         REG_RUN_BAND:     cf_run_band = val[30:0];
         REG_LOCK_BAND:    cf_lock_band = val[30:0];
         REG_HEADING_BAND: cf_heading_band = val[30:0];
         REG_HEADING_GAIN: cf_heading_gain = val[15:0];
         REG_LOCK_GAIN:    cf_lock_gain = val[15:0];
         REG_SPEED_SCALE:  cf_speed_scale = val[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(bit sm, int pc, longint rb, longint lb, longint hb,
                            int hg, int lg, int sc);
      csr_write(REG_POINT_COUNT, 32'(pc));
      csr_write(REG_RUN_BAND, 32'(rb));
      csr_write(REG_LOCK_BAND, 32'(lb));
      csr_write(REG_HEADING_BAND, 32'(hb));
      csr_write(REG_HEADING_GAIN, 32'(hg));
      csr_write(REG_LOCK_GAIN, 32'(lg));
      csr_write(REG_SPEED_SCALE, 32'(sc));
      csr_write(REG_START_MODE, {31'd0, sm});
      gen_aim = 0;
   endtask

   // Mostly poses near the next waypoint, some rewrites and some noise
   task automatic random_items(int n);
      int     k, r, s;
      longint ox, oy;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         s = (gen_aim < MAX_POINTS) ? gen_aim : MAX_POINTS - 1;
         if (r < 12) begin
            push_load($urandom_range(0, MAX_POINTS - 1), $signed(pick_word()),
                      $signed(pick_word()), $signed(pick_word()), pick_word());
         end else if (r < 62) begin
            ox = $signed($urandom_range(0, 2 * 400000)) - 400000;
            oy = $signed($urandom_range(0, 2 * 400000)) - 400000;
            push_pose(gen_x[s] + ox, gen_y[s] + oy,
                      gen_h[s] + $signed($urandom_range(0, 400000)) - 200000);
            if (mag(ox) + mag(oy) < 300000) gen_aim++;
         end else if (r < 82) begin
            push_pose(gen_x[s] + $signed($urandom_range(0, 40000000)) - 20000000,
                      gen_y[s] + $signed($urandom_range(0, 40000000)) - 20000000,
                      $signed($urandom));
         end else begin
            push_pose($signed(pick_word()), $signed(pick_word()), $signed(pick_word()));
         end
      end
   endtask

   initial begin
      int i;
      cf_start_mode = 0;
      cf_point_count = 0;
      cf_run_band = 655360;
      cf_lock_band = 65536;
      cf_heading_band = 65536;
      cf_heading_gain = 256;
      cf_lock_gain = 256;
      cf_speed_scale = 256;
      target_idx = 0;
      lock_mode = 0;
      last_vx = '0;
      last_vy = '0;
      last_turn = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Fill every slot so no pose reads an unwritten waypoint
      quiet = 1'b1;
      for (i = 0; i < MAX_POINTS; i++)
         push_load(i, i * 1000000, -i * 700000, i * 30000, 200000 + i);
      drain();
      quiet = 1'b0;

      // Directed: extremes, zero distance, heading band edges, path ends
      configure(0, 4, 655360, 65536, 65536, 256, 256, 256);
      push_pose(0, 0, 0);
      push_pose(0, 0, 0);
      push_pose(1000000, -700000, 30000 + 65536);
      push_pose(1000000, -700000, 30000 - 65537);
      push_load(2, 32'sh7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000, 31'h7FFF_FFFF);
      push_load(63, -32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h0);
      push_pose(-32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      push_pose(2000000, -1400000, 60000);
      push_pose(3000000, -2100000, 90000);
      push_pose(3000000, -2100000, -32'sh8000_0000);
      push_pose(32'sh7FFF_FFFF, -32'sh8000_0000, 0);
      drain();
      configure(1, 0, 0, 2147483647, 0, 65535, 65535, 65535);
      push_pose(-32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      push_pose(5, -5, 0);
      push_pose(0, 0, 1);
      drain();
      configure(0, 127, 2147483647, 0, 2147483647, 0, 0, 0);
      push_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      push_pose(0, 0, 0);
      drain();

      // Random phases over a spread of settings
      configure(0, 8, 655360, 65536, 65536, 256, 256, 256);
      random_items(90);
      // Once half the backlog is sent, hold the rest until every expected result has come
      while (pending_words.size() > 45) @(posedge clock);
      hold_req = 1'b1;
      while (req_valid || velocity_queue.size() > 0) @(posedge clock);
      hold_req = 1'b0;
      drain();
      configure(1, 16, 300000, 300000, 0, 65535, 65535, 512);
      random_items(80);
      drain();
      quiet = 1'b1;
      configure(0, 64, 2147483647, 0, 2147483647, 0, 0, 65535);
      random_items(70);
      drain();
      quiet = 1'b0;
      configure(0, 1, 0, 2147483647, 100000, 1, 1, 1);
      random_items(70);
      drain();
      configure($urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 2000000),
                $urandom_range(0, 2000000), $urandom_range(0, 2000000),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535));
      random_items(90);
      drain();
      configure(0, 12, 800000, 400000, 50000, 512, 128, 384);
      random_items(100);
      drain();
      configure(1, 0, 655360, 65536, 65536, 256, 256, 256);
      random_items(80);
      drain();

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- waypoint_follower_velocity.f -----
design/wfv_pkg.sv
design/wfv_ram.sv
design/wfv_ctrl.sv
design/wfv_dp.sv
design/waypoint_follower_velocity.sv
tb/sv/waypoint_follower_velocity_test.sv
